/* src/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared widths, operation codes and status codes of the two-class queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned TagW    = 32;
  localparam int unsigned AgeW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 6;

  // slave side tdata: tag, age, padded to whole bytes
  localparam int unsigned STdataW = 40;
  // master side tdata: tag, age, occupancy, padded to whole bytes
  localparam int unsigned MTdataW = 48;
  // master side tuser: status, priority flag
  localparam int unsigned MTuserW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_ENQ_NORMAL = 2'd0,
    KIND_ENQ_PRIO   = 2'd1,
    KIND_DEQ        = 2'd2,
    KIND_FLUSH      = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

/* src/two_class_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_core
// strict two-class priority queue; each class is a ring buffer in its own
// synchronous memory, dequeue serves the priority class first
// ----------------------------------------------------------------------------
//  channel   direction  tvalid/tready  tdata                      tuser
//  s_axis    in         transfer       tag, age                   kind
//  m_axis    out        transfer       tag, age, occupancy        status, priority
//
// enqueue, flush and a dequeue of an empty queue go straight to the result register; a dequeue that
// hands out an entry passes the class memory read register and then the result register.
// one result per input transfer, in input order.
// reset clears pointers, counts, the pending dequeue and the output valid; memory contents stay undefined.
// a stalled result register blocks new input transfers until it drains.
module two_class_priority_queue_core #(
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [31:0] customer_tag, [38:32] customer_age, [39] zero
  input  logic [tcpq_pkg::STdataW-1:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [tcpq_pkg::KindW-1:0]  s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [31:0] out_tag, [38:32] out_age, [44:39] occupancy, [47:45] zero
  output logic [tcpq_pkg::MTdataW-1:0] m_axis_tdata_o,
  // [1:0] status, [2] out_priority
  output logic [tcpq_pkg::MTuserW-1:0] m_axis_tuser_o
);

  localparam int unsigned PtrW  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned SumW  = (CntW + 1 > tcpq_pkg::OccW) ? CntW + 1 : tcpq_pkg::OccW;
  localparam int unsigned STagW = (TAG_BITS < tcpq_pkg::TagW) ? TAG_BITS : tcpq_pkg::TagW;
  localparam int unsigned EntW  = STagW + tcpq_pkg::AgeW;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(CLASS_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CLASS_DEPTH);

  // ring buffers
  logic [EntW-1:0] prio_mem_q [CLASS_DEPTH];
  logic [EntW-1:0] norm_mem_q [CLASS_DEPTH];
  logic [EntW-1:0] prio_rd_q, norm_rd_q;

  logic [PtrW-1:0] p_head_q, p_head_d, p_tail_q, p_tail_d;
  logic [PtrW-1:0] n_head_q, n_head_d, n_tail_q, n_tail_d;
  logic [CntW-1:0] p_cnt_q, p_cnt_d, n_cnt_q, n_cnt_d;

  // dequeue waiting for read data
  logic                      pend_q, pend_d;
  logic                      pend_prio_q, pend_prio_d;
  logic [tcpq_pkg::OccW-1:0] pend_occ_q, pend_occ_d;

  logic                        m_valid_q, m_valid_d;
  logic [tcpq_pkg::MTdataW-1:0] m_data_q, m_data_d;
  logic [tcpq_pkg::MTuserW-1:0] m_user_q, m_user_d;

  logic                      accept, out_free;
  logic                      wr_prio, wr_norm, rd_prio, rd_norm;
  logic                      res_now;
  tcpq_pkg::status_e         res_status;
  logic [EntW-1:0]           wr_ent, deq_ent;
  logic [SumW-1:0]           occ_sum;
  logic [tcpq_pkg::OccW-1:0] occ;
  logic [tcpq_pkg::TagW-1:0] in_tag, deq_tag;
  logic [tcpq_pkg::AgeW-1:0] in_age, deq_age;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !pend_q && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_tag = s_axis_tdata_i[tcpq_pkg::TagW-1:0];
  assign in_age = s_axis_tdata_i[tcpq_pkg::TagW +: tcpq_pkg::AgeW];
  assign wr_ent = {in_age, in_tag[STagW-1:0]};

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    p_head_d    = p_head_q;
    p_tail_d    = p_tail_q;
    p_cnt_d     = p_cnt_q;
    n_head_d    = n_head_q;
    n_tail_d    = n_tail_q;
    n_cnt_d     = n_cnt_q;
    wr_prio     = 1'b0;
    wr_norm     = 1'b0;
    rd_prio     = 1'b0;
    rd_norm     = 1'b0;
    res_now     = 1'b0;
    res_status  = tcpq_pkg::STATUS_DONE;
    pend_prio_d = pend_prio_q;
    if (accept) begin
      unique case (tcpq_pkg::kind_e'(s_axis_tuser_i))
        tcpq_pkg::KIND_ENQ_NORMAL: begin
          res_now = 1'b1;
          if (n_cnt_q == CntFull) begin
            res_status = tcpq_pkg::STATUS_FULL;
          end else begin
            wr_norm  = 1'b1;
            n_tail_d = ptr_next(n_tail_q);
            n_cnt_d  = n_cnt_q + CntW'(1);
          end
        end
        tcpq_pkg::KIND_ENQ_PRIO: begin
          res_now = 1'b1;
          if (p_cnt_q == CntFull) begin
            res_status = tcpq_pkg::STATUS_FULL;
          end else begin
            wr_prio  = 1'b1;
            p_tail_d = ptr_next(p_tail_q);
            p_cnt_d  = p_cnt_q + CntW'(1);
          end
        end
        tcpq_pkg::KIND_DEQ: begin
          if (p_cnt_q != '0) begin
            rd_prio     = 1'b1;
            pend_prio_d = 1'b1;
            p_head_d    = ptr_next(p_head_q);
            p_cnt_d     = p_cnt_q - CntW'(1);
          end else if (n_cnt_q != '0) begin
            rd_norm     = 1'b1;
            pend_prio_d = 1'b0;
            n_head_d    = ptr_next(n_head_q);
            n_cnt_d     = n_cnt_q - CntW'(1);
          end else begin
            res_now    = 1'b1;
            res_status = tcpq_pkg::STATUS_EMPTY;
          end
        end
        tcpq_pkg::KIND_FLUSH: begin
          res_now  = 1'b1;
          p_head_d = '0;
          p_tail_d = '0;
          p_cnt_d  = '0;
          n_head_d = '0;
          n_tail_d = '0;
          n_cnt_d  = '0;
        end
        default: begin
          res_now = 1'b1;
        end
      endcase
    end
  end

  assign occ_sum    = SumW'(p_cnt_d) + SumW'(n_cnt_d);
  assign occ        = occ_sum[tcpq_pkg::OccW-1:0];
  assign pend_d     = rd_prio || rd_norm;
  assign pend_occ_d = pend_d ? occ : pend_occ_q;

  assign deq_ent = pend_prio_q ? prio_rd_q : norm_rd_q;
  assign deq_tag = tcpq_pkg::TagW'(deq_ent[STagW-1:0]);
  assign deq_age = deq_ent[STagW +: tcpq_pkg::AgeW];

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (res_now) begin
      m_valid_d = 1'b1;
      m_data_d  = {(tcpq_pkg::MTdataW - tcpq_pkg::TagW - tcpq_pkg::AgeW)'(occ),
                   {tcpq_pkg::AgeW{1'b0}}, {tcpq_pkg::TagW{1'b0}}};
      m_user_d  = {1'b0, res_status};
    end else if (pend_q) begin
      m_valid_d = 1'b1;
      m_data_d  = {(tcpq_pkg::MTdataW - tcpq_pkg::TagW - tcpq_pkg::AgeW)'(pend_occ_q),
                   deq_age, deq_tag};
      m_user_d  = {pend_prio_q, tcpq_pkg::STATUS_DONE};
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_head_q    <= '0;
      p_tail_q    <= '0;
      p_cnt_q     <= '0;
      n_head_q    <= '0;
      n_tail_q    <= '0;
      n_cnt_q     <= '0;
      pend_q      <= 1'b0;
      pend_prio_q <= 1'b0;
      pend_occ_q  <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      p_head_q    <= p_head_d;
      p_tail_q    <= p_tail_d;
      p_cnt_q     <= p_cnt_d;
      n_head_q    <= n_head_d;
      n_tail_q    <= n_tail_d;
      n_cnt_q     <= n_cnt_d;
      pend_q      <= pend_d;
      pend_prio_q <= pend_prio_d;
      pend_occ_q  <= pend_occ_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // memory ports; a dequeue right after an enqueue reads after the write edge
  always_ff @(posedge clk_i) begin
    if (wr_prio) begin
      prio_mem_q[p_tail_q] <= wr_ent;
    end
    if (rd_prio) begin
      prio_rd_q <= prio_mem_q[p_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_norm) begin
      norm_mem_q[n_tail_q] <= wr_ent;
    end
    if (rd_norm) begin
      norm_rd_q <= norm_mem_q[n_head_q];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

/* src/tcpq_checker.sv */
// ----------------------------------------------------------------------------
// tcpq_checker
// port-level checks of the two-class queue results
// ----------------------------------------------------------------------------
module tcpq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid_i,
  input logic                         m_axis_tready_i,
  input logic [tcpq_pkg::MTdataW-1:0] m_axis_tdata_i,
  input logic [tcpq_pkg::MTuserW-1:0] m_axis_tuser_i
);

  logic [tcpq_pkg::StatusW-1:0] status;
  logic                         prio;
  logic [tcpq_pkg::TagW-1:0]    tag;
  logic [tcpq_pkg::AgeW-1:0]    age;
  logic [tcpq_pkg::OccW-1:0]    occ;

  assign status = m_axis_tuser_i[tcpq_pkg::StatusW-1:0];
  assign prio   = m_axis_tuser_i[tcpq_pkg::StatusW];
  assign tag    = m_axis_tdata_i[tcpq_pkg::TagW-1:0];
  assign age    = m_axis_tdata_i[tcpq_pkg::TagW +: tcpq_pkg::AgeW];
  assign occ    = m_axis_tdata_i[tcpq_pkg::TagW + tcpq_pkg::AgeW +: tcpq_pkg::OccW];

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (status == tcpq_pkg::STATUS_DONE ||
                         status == tcpq_pkg::STATUS_FULL ||
                         status == tcpq_pkg::STATUS_EMPTY))
    else $error("undefined status code");

  // empty queue reports no entry and zero occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && status == tcpq_pkg::STATUS_EMPTY |->
      tag == '0 && age == '0 && !prio && occ == '0)
    else $error("empty result carries data");

  // a refused enqueue hands out no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && status == tcpq_pkg::STATUS_FULL |->
      tag == '0 && age == '0 && !prio)
    else $error("refused result carries an entry");

endmodule

bind two_class_priority_queue_core tcpq_checker u_tcpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

/* tb/sv/two_class_priority_queue_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_core_tb
// stream-level test of the two-class queue: a directed opening (empty
// dequeue, flushes, field extremes, strict class order, a full priority
// class) and then random phases that fill and drain both classes. every
// accepted command is run through a local model of the two rings; each
// returned transfer is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module two_class_priority_queue_core_tb;

  localparam int unsigned ClassDepth = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldAt     = 120;
  localparam int unsigned HoldLen    = 80;

  typedef struct packed {
    logic [tcpq_pkg::TagW-1:0] tag;
    logic [tcpq_pkg::AgeW-1:0] age;
  } entry_t;

  typedef struct packed {
    tcpq_pkg::kind_e           kind;
    logic [tcpq_pkg::TagW-1:0] tag;
    logic [tcpq_pkg::AgeW-1:0] age;
  } cmd_t;

  typedef struct packed {
    tcpq_pkg::status_e         status;
    logic [tcpq_pkg::TagW-1:0] tag;
    logic [tcpq_pkg::AgeW-1:0] age;
    logic                      prio;
    logic [tcpq_pkg::OccW-1:0] occ;
  } answer_t;

  logic                          clk_i   = 1'b0;
  logic                          rst_ni  = 1'b0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [tcpq_pkg::STdataW-1:0]  s_tdata = '0;
  logic [tcpq_pkg::KindW-1:0]    s_tuser = '0;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [tcpq_pkg::MTdataW-1:0]  m_tdata;
  logic [tcpq_pkg::MTuserW-1:0]  m_tuser;

  cmd_t    cmd_backlog[$];
  answer_t answers_due[$];
  entry_t  prio_line[$];
  entry_t  norm_line[$];

  int unsigned send_gap   = 0;
  int unsigned recv_gap   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  bit          calm       = 1'b0;
  int unsigned cmds_taken = 0;
  int unsigned quiet_cyc  = 0;
  int unsigned errors     = 0;

  two_class_priority_queue_core #(
    .CLASS_DEPTH(ClassDepth),
    .TAG_BITS   (tcpq_pkg::TagW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // apply one command to the local rings and return what the block must answer
  function automatic answer_t serve_cmd(tcpq_pkg::kind_e kind,
                                        logic [tcpq_pkg::TagW-1:0] tag,
                                        logic [tcpq_pkg::AgeW-1:0] age);
    answer_t r;
    entry_t  e;
    r.status = tcpq_pkg::STATUS_DONE;
    r.tag    = '0;
    r.age    = '0;
    r.prio   = 1'b0;
    e.tag    = tag;
    e.age    = age;
    case (kind)
      tcpq_pkg::KIND_ENQ_NORMAL: begin
        if (norm_line.size() >= ClassDepth) r.status = tcpq_pkg::STATUS_FULL;
        else norm_line.push_back(e);
      end
      tcpq_pkg::KIND_ENQ_PRIO: begin
        if (prio_line.size() >= ClassDepth) r.status = tcpq_pkg::STATUS_FULL;
        else prio_line.push_back(e);
      end
      tcpq_pkg::KIND_DEQ: begin
        if (prio_line.size() != 0) begin
          e      = prio_line.pop_front();
          r.tag  = e.tag;
          r.age  = e.age;
          r.prio = 1'b1;
        end else if (norm_line.size() != 0) begin
          e     = norm_line.pop_front();
          r.tag = e.tag;
          r.age = e.age;
        end else begin
          r.status = tcpq_pkg::STATUS_EMPTY;
        end
      end
      default: begin
        prio_line.delete();
        norm_line.delete();
      end
    endcase
    r.occ = tcpq_pkg::OccW'(prio_line.size() + norm_line.size());
    return r;
  endfunction

  // sender: holds tvalid and data until the transfer completes
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      send_gap <= 0;
    end else if (!s_valid || s_ready) begin
      if (send_gap != 0) begin
        s_valid  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog.pop_front();
        s_valid <= 1'b1;
        s_tdata <= {1'b0, c.age, c.tag};
        s_tuser <= c.kind;
        if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver: random idle bursts plus one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && cmds_taken == HoldAt) begin
      m_ready   <= 1'b0;
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (recv_gap != 0) begin
      m_ready  <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      m_ready  <= 1'b0;
      recv_gap <= $urandom_range(0, 11);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // monitor: predict on every input transfer, then check every output transfer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        answers_due.push_back(serve_cmd(tcpq_pkg::kind_e'(s_tuser),
                                        s_tdata[tcpq_pkg::TagW-1:0],
                                        s_tdata[tcpq_pkg::TagW +: tcpq_pkg::AgeW]));
        cmds_taken <= cmds_taken + 1;
      end
      if (m_valid && m_ready) begin
        if (answers_due.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (m_tuser[tcpq_pkg::StatusW-1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status,
                   m_tuser[tcpq_pkg::StatusW-1:0]);
            errors++;
          end
          if (m_tdata[tcpq_pkg::TagW-1:0] !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag,
                   m_tdata[tcpq_pkg::TagW-1:0]);
            errors++;
          end
          if (m_tdata[tcpq_pkg::TagW +: tcpq_pkg::AgeW] !== want.age) begin
            $error("out_age: expected %0d, got %0d", want.age,
                   m_tdata[tcpq_pkg::TagW +: tcpq_pkg::AgeW]);
            errors++;
          end
          if (m_tuser[tcpq_pkg::StatusW] !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio,
                   m_tuser[tcpq_pkg::StatusW]);
            errors++;
          end
          if (m_tdata[tcpq_pkg::TagW + tcpq_pkg::AgeW +: tcpq_pkg::OccW] !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ,
                   m_tdata[tcpq_pkg::TagW + tcpq_pkg::AgeW +: tcpq_pkg::OccW]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= StallLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  task automatic queue_cmd(tcpq_pkg::kind_e kind, logic [tcpq_pkg::TagW-1:0] tag,
                           logic [tcpq_pkg::AgeW-1:0] age);
    cmd_t c;
    c.kind = kind;
    c.tag  = tag;
    c.age  = age;
    cmd_backlog.push_back(c);
  endtask

  // one random phase; the mix decides whether the classes fill up or drain
  task automatic queue_phase(int n, int enq_pct, int prio_pct, int flush_pct);
    int r;
    tcpq_pkg::kind_e k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < flush_pct) k = tcpq_pkg::KIND_FLUSH;
      else if (r < flush_pct + enq_pct)
        k = ($urandom_range(0, 99) < prio_pct) ? tcpq_pkg::KIND_ENQ_PRIO
                                               : tcpq_pkg::KIND_ENQ_NORMAL;
      else k = tcpq_pkg::KIND_DEQ;
      queue_cmd(k, $urandom, tcpq_pkg::AgeW'($urandom_range(0, 127)));
    end
  endtask

  // sampled away from the rising edge so the driver and monitor have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || s_valid || answers_due.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_cmd(tcpq_pkg::KIND_DEQ, 32'h0, 7'd0);
    queue_cmd(tcpq_pkg::KIND_FLUSH, 32'h0, 7'd0);
    queue_cmd(tcpq_pkg::KIND_ENQ_NORMAL, 32'h0000_0000, 7'd0);
    queue_cmd(tcpq_pkg::KIND_ENQ_NORMAL, 32'hffff_ffff, 7'd127);
    queue_cmd(tcpq_pkg::KIND_ENQ_PRIO, 32'h5555_5555, 7'h2a);
    queue_cmd(tcpq_pkg::KIND_ENQ_PRIO, 32'haaaa_aaaa, 7'h55);
    // priority entries leave first, each class in arrival order
    repeat (4) queue_cmd(tcpq_pkg::KIND_DEQ, $urandom,
                         tcpq_pkg::AgeW'($urandom_range(0, 127)));
    queue_cmd(tcpq_pkg::KIND_DEQ, 32'hffff_ffff, 7'd127);
    queue_cmd(tcpq_pkg::KIND_ENQ_NORMAL, $urandom, tcpq_pkg::AgeW'($urandom_range(0, 127)));
    queue_cmd(tcpq_pkg::KIND_ENQ_PRIO, $urandom, tcpq_pkg::AgeW'($urandom_range(0, 127)));
    queue_cmd(tcpq_pkg::KIND_FLUSH, 32'hffff_ffff, 7'd127);
    queue_cmd(tcpq_pkg::KIND_DEQ, 32'h0, 7'd0);
    // one more than the class holds, the last one is refused
    repeat (ClassDepth + 1) queue_cmd(tcpq_pkg::KIND_ENQ_PRIO, $urandom,
                                      tcpq_pkg::AgeW'($urandom_range(0, 127)));
    wait_drained();

    queue_phase(50, 50, 50, 2);
    queue_phase(50, 85, 30, 0);
    queue_phase(50, 85, 70, 0);
    wait_drained();
    queue_phase(50, 20, 50, 0);
    queue_phase(50, 50, 50, 8);
    queue_phase(60, 90, 50, 0);
    queue_phase(60, 10, 50, 0);
    wait_drained();

    calm = 1'b1;
    queue_phase(50, 55, 50, 3);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (errors == 0 && answers_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
